// ===== sv/wodf_pkg.sv =====
// Shared types, widths and field offsets for the wheel odometry direction filter.
// Depends on nothing; every other file of the block imports it.
package wodf_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int BYTE_WIDTH   = 8;
   localparam int TOTAL_WIDTH  = 32;
   localparam int SSPEED_WIDTH = BYTE_WIDTH + 1;
   localparam int CFG_WIDTH    = 16;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(300);

   // Width used when the counter is compared against the glitch limit.
   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   // Direction byte: left wheel in bits 7:6, right wheel in bits 5:4.
   localparam int DIR_LEFT_LSB  = 6;
   localparam int DIR_RIGHT_LSB = 4;

   // Request tdata layout, lowest bits first.
   localparam int REQ_DIR_LSB    = 0;
   localparam int REQ_LSPEED_LSB = REQ_DIR_LSB + BYTE_WIDTH;
   localparam int REQ_RSPEED_LSB = REQ_LSPEED_LSB + BYTE_WIDTH;
   localparam int REQ_LCOUNT_LSB = REQ_RSPEED_LSB + BYTE_WIDTH;
   localparam int REQ_RCOUNT_LSB = REQ_LCOUNT_LSB + COUNT_WIDTH;
   localparam int REQ_FIELDS     = REQ_RCOUNT_LSB + COUNT_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_FIELDS + 7) / 8) * 8;

   // Response tdata layout, lowest bits first.
   localparam int RSP_FIELDS     = 4 * TOTAL_WIDTH + 2 * SSPEED_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELDS + 7) / 8) * 8;

   // Two's complement direction codes: stop, forward (+1), reverse (-1).
   typedef enum logic [1:0] {
      DIR_STOP = 2'b00,
      DIR_FWD  = 2'b01,
      DIR_REV  = 2'b11
   } dir_type;

   typedef struct packed {
      logic signed [TOTAL_WIDTH-1:0]  signed_total;
      logic        [TOTAL_WIDTH-1:0]  abs_total;
      logic signed [SSPEED_WIDTH-1:0] signed_speed;
   } lane_result_type;

   function automatic dir_type decode_dir(input logic [1:0] pair);
      dir_type d;
      if (pair == 2'b11) begin
         d = DIR_FWD;
      end else if (pair[1]) begin
         d = DIR_REV;
      end else begin
         d = DIR_STOP;
      end
      return d;
   endfunction

   function automatic dir_type negate_dir(input dir_type d);
      dir_type n;
      unique case (d)
         DIR_FWD: n = DIR_REV;
         DIR_REV: n = DIR_FWD;
         default: n = DIR_STOP;
      endcase
      return n;
   endfunction

endpackage

// ===== sv/wodf_lane.sv =====
// One wheel lane: direction filter, tick magnitude, running totals and signed speed.
// Depends on wodf_pkg.
module wodf_lane
   import wodf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic [1:0]             dir_pair,
   input  logic [BYTE_WIDTH-1:0]  speed,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [CFG_WIDTH-1:0]   max_ticks,
   output lane_result_type        result
);

   logic [COUNT_WIDTH-1:0] prev_count_ff, prev_count_in;
   dir_type                conf_dir_ff, conf_dir_in;
   logic                   pending_ff, pending_in;
   logic [TOTAL_WIDTH-1:0] abs_ff, abs_in;
   logic [TOTAL_WIDTH-1:0] signed_ff, signed_in;

   dir_type                reported;
   logic                   is_reset;
   logic [COUNT_WIDTH-1:0] mag;
   logic [SSPEED_WIDTH-1:0] speed_ext;
   logic [SSPEED_WIDTH-1:0] speed_val;

   always_comb begin
      reported   = decode_dir(dir_pair);
      is_reset   = count < prev_count_ff;
      conf_dir_in = conf_dir_ff;
      pending_in  = pending_ff;

      if (reported != DIR_STOP && (speed != '0 || conf_dir_ff == DIR_STOP)) begin
         conf_dir_in = reported;
         pending_in  = 1'b0;
      end else if (reported == negate_dir(conf_dir_ff)) begin
         // Unconfirmed reversal: the second counter reset adopts it.
         if (is_reset) begin
            if (pending_ff) begin
               conf_dir_in = reported;
               pending_in  = 1'b0;
            end else begin
               pending_in  = 1'b1;
            end
         end
      end else begin
         pending_in = 1'b0;
      end

      mag = '0;
      if (reported != DIR_STOP) begin
         if (!is_reset) begin
            mag = count - prev_count_ff;
         end else if (CMP_WIDTH'(count) <= CMP_WIDTH'(max_ticks)) begin
            mag = count;
         end
      end

      prev_count_in = count;
      abs_in        = abs_ff + TOTAL_WIDTH'(mag);
      case (conf_dir_in)
         DIR_FWD: signed_in = signed_ff + TOTAL_WIDTH'(mag);
         DIR_REV: signed_in = signed_ff - TOTAL_WIDTH'(mag);
         default: signed_in = signed_ff;
      endcase

      speed_ext = SSPEED_WIDTH'(speed);
      case (conf_dir_in)
         DIR_FWD: speed_val = speed_ext;
         DIR_REV: speed_val = '0 - speed_ext;
         default: speed_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         conf_dir_ff   <= DIR_STOP;
         pending_ff    <= 1'b0;
         abs_ff        <= '0;
         signed_ff     <= '0;
      end else if (enable) begin
         prev_count_ff <= prev_count_in;
         conf_dir_ff   <= conf_dir_in;
         pending_ff    <= pending_in;
         abs_ff        <= abs_in;
         signed_ff     <= signed_in;
      end
   end

   assign result.signed_total = signed_in;
   assign result.abs_total    = abs_in;
   assign result.signed_speed = speed_val;

endmodule

// ===== sv/wodf_merge.sv =====
// Merging stage: packs both lane results into the response register.
// Depends on wodf_pkg.
module wodf_merge
   import wodf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  lane_result_type           left,
   input  lane_result_type           right,
   output logic                      room,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   logic                      valid_ff, valid_in;
   logic [RSP_DATA_WIDTH-1:0] data_ff, data_in;

   // The register can take a new transaction when empty or drained this cycle.
   assign room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (room) begin
         valid_in = load;
      end
      data_in = RSP_DATA_WIDTH'({right.signed_speed, left.signed_speed,
                                 right.abs_total, left.abs_total,
                                 right.signed_total, left.signed_total});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (room && load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== sv/wheel_odometry_direction_filter.sv =====
// Top level of the wheel odometry direction filter: two wheel lanes and the merge stage.
// Depends on wodf_pkg, wodf_lane and wodf_merge.
//
//   channel | direction | handshake            | content
//   --------+-----------+----------------------+----------------------------------
//   req     | in        | tvalid/tready        | one status frame, tuser = valid
//   rsp     | out       | tvalid/tready        | totals and signed speeds
//   csr     | in        | we, no ready         | max_ticks_per_frame
//
// One transaction is taken per clock cycle while the response register has room. For a
// valid frame both lanes update their state in the cycle of acceptance and the result
// appears in the response register on the next cycle; invalid frames change neither.
// The rate rests on the combinational state update of each lane (compare, subtract
// and a 32-bit add). Reset is synchronous and active high; it clears all wheel state
// and loads the glitch limit with 300. A stalled response holds its data, and the
// request side keeps flowing whenever the response register is empty or is being
// drained in the same cycle.
module wheel_odometry_direction_filter
   import wodf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0: direction_byte, left speed byte, right speed byte, left_count,
   // right_count.
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // Fields from bit 0: frame_valid.
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0: left_signed_total, right_signed_total, left_abs_total,
   // right_abs_total, left_signed_speed, right_signed_speed, zero fill.
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CFG_WIDTH-1:0]      csr_wdata
);

   logic [CFG_WIDTH-1:0] max_ticks_ff;
   logic                 room;
   logic                 lane_enable;
   lane_result_type      left_result;
   lane_result_type      right_result;
   logic [BYTE_WIDTH-1:0] dir_byte;

   // The glitch limit register; the user must write it only while the block is idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ticks_ff <= CFG_RESET;
      end else if (csr_we) begin
         max_ticks_ff <= csr_wdata;
      end
   end

   assign req_tready = room;

   // Frames that failed their checks are accepted and dropped without touching state.
   assign lane_enable = req_tvalid && room && req_tuser;
   assign dir_byte    = req_tdata[REQ_DIR_LSB +: BYTE_WIDTH];

   wodf_lane u_left (
      .clock     (clock),
      .reset     (reset),
      .enable    (lane_enable),
      .dir_pair  (dir_byte[DIR_LEFT_LSB +: 2]),
      .speed     (req_tdata[REQ_LSPEED_LSB +: BYTE_WIDTH]),
      .count     (req_tdata[REQ_LCOUNT_LSB +: COUNT_WIDTH]),
      .max_ticks (max_ticks_ff),
      .result    (left_result)
   );

   wodf_lane u_right (
      .clock     (clock),
      .reset     (reset),
      .enable    (lane_enable),
      .dir_pair  (dir_byte[DIR_RIGHT_LSB +: 2]),
      .speed     (req_tdata[REQ_RSPEED_LSB +: BYTE_WIDTH]),
      .count     (req_tdata[REQ_RCOUNT_LSB +: COUNT_WIDTH]),
      .max_ticks (max_ticks_ff),
      .result    (right_result)
   );

   // The merge stage registers both lane results as one response transaction.
   wodf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (lane_enable),
      .left       (left_result),
      .right      (right_result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== sv/wodf_checker.sv =====
// Port-level checks for the wheel odometry direction filter, bound to the top level.
// Depends on wodf_pkg and wheel_odometry_direction_filter.
module wodf_checker
   import wodf_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response keeps its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An empty output stage never stalls the request side.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output empty");

   // A valid frame always yields a response in the next cycle.
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> rsp_tvalid)
      else $error("valid frame produced no response");

   // A dropped frame yields no response when nothing else is pending.
   a_drop: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && (!rsp_tvalid || rsp_tready)
      |=> !rsp_tvalid)
      else $error("invalid frame produced a response");

endmodule

bind wheel_odometry_direction_filter wodf_checker u_wodf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_wheel_odometry_direction_filter.sv =====
// Self-checking testbench for wheel_odometry_direction_filter: a directed table, then random
// status frames under changing back-pressure, each result compared with an in-bench predictor.
// Depends on wodf_pkg and the block's RTL only.
module tb_wheel_odometry_direction_filter
   import wodf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles the block may still need after the last result has arrived.
   localparam int SETTLE_CYCLES = 4;
   // Length of the deliberate receiver hold-off that fills the block.
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_FRAMES  = 200;
   localparam int DIRECTED_ROWS = 18;
   localparam int RSP_SPEED_LSB = 4 * TOTAL_WIDTH;

   // One status frame as the bench sees it, before it is packed onto the request bus.
   typedef struct packed {
      logic                   frame_ok;
      logic [BYTE_WIDTH-1:0]  direction;
      logic [BYTE_WIDTH-1:0]  lspeed;
      logic [BYTE_WIDTH-1:0]  rspeed;
      logic [COUNT_WIDTH-1:0] left_count;
      logic [COUNT_WIDTH-1:0] right_count;
   } status_frame_type;

   // One odometry result, unpacked from the response bus.
   typedef struct packed {
      logic signed [TOTAL_WIDTH-1:0]  left_signed_total;
      logic signed [TOTAL_WIDTH-1:0]  right_signed_total;
      logic        [TOTAL_WIDTH-1:0]  left_abs_total;
      logic        [TOTAL_WIDTH-1:0]  right_abs_total;
      logic signed [SSPEED_WIDTH-1:0] left_signed_speed;
      logic signed [SSPEED_WIDTH-1:0] right_signed_speed;
   } odo_result_type;

   typedef struct {
      status_frame_type frame;
      bit               known;
      odo_result_type   want;
   } table_row_type;

   localparam odo_result_type NO_TICKS = '0;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata   = '0;
   logic                      req_tuser   = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we      = 1'b0;
   logic [CFG_WIDTH-1:0]      csr_wdata   = '0;

   // Predictor state: a private copy of the per-wheel odometry state and the glitch limit.
   logic [COUNT_WIDTH-1:0] last_count [2];
   dir_type                heading [2];
   logic                   reset_seen [2];
   logic [TOTAL_WIDTH-1:0] tick_sum [2];
   logic [TOTAL_WIDTH-1:0] signed_sum [2];
   logic [CFG_WIDTH-1:0]   glitch_limit;

   // Expected results, oldest first, one per accepted valid frame.
   odo_result_type pending_odometry [$];

   // State of the random frame generator; it follows the counters the block last saw.
   logic [COUNT_WIDTH-1:0] gen_count [2];
   logic [1:0]             gen_pair [2];

   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int errors          = 0;
   int frames_accepted = 0;
   int results_checked = 0;
   int glitch_drops    = 0;
   int late_reversals  = 0;

   wheel_odometry_direction_filter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      for (int w = 0; w < 2; w++) begin
         last_count[w] = '0;
         heading[w]    = DIR_STOP;
         reset_seen[w] = 1'b0;
         tick_sum[w]   = '0;
         signed_sum[w] = '0;
         gen_count[w]  = '0;
         gen_pair[w]   = 2'b00;
      end
      glitch_limit = CFG_RESET;
   end

   // The first ten failures are printed in full; after that they are only counted.
   function automatic void flag_error(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void check_field(input string name, input logic [TOTAL_WIDTH-1:0] want,
                                       input logic [TOTAL_WIDTH-1:0] got);
      if (got !== want) begin
         flag_error($sformatf("%s: expected %h, got %h", name, want, got));
      end
   endfunction

   // Updates one wheel for one valid frame and returns its new totals and signed speed.
   function automatic void advance_wheel(input int w, input logic [1:0] pair,
                                         input logic [BYTE_WIDTH-1:0] speed,
                                         input logic [COUNT_WIDTH-1:0] count,
                                         output logic [TOTAL_WIDTH-1:0] signed_total,
                                         output logic [TOTAL_WIDTH-1:0] abs_total,
                                         output logic [SSPEED_WIDTH-1:0] signed_speed);
      dir_type                reported;
      dir_type                held;
      logic [1:0]             opposite;
      logic                   wrapped;
      logic [COUNT_WIDTH-1:0] ticks;
      case (pair)
         2'b11:   reported = DIR_FWD;
         2'b10:   reported = DIR_REV;
         default: reported = DIR_STOP;
      endcase
      wrapped  = count < last_count[w];
      held     = heading[w];
      opposite = -held;
      if (reported != DIR_STOP && (speed != '0 || held == DIR_STOP)) begin
         // A moving report, or any report while stopped, is taken at once.
         held = reported;
         reset_seen[w] = 1'b0;
      end else if (reported == opposite) begin
         // An unconfirmed reversal needs two counter resets in a row.
         if (wrapped) begin
            if (reset_seen[w]) begin
               if (held != reported) begin
                  late_reversals++;
               end
               held = reported;
               reset_seen[w] = 1'b0;
            end else begin
               reset_seen[w] = 1'b1;
            end
         end
      end else begin
         reset_seen[w] = 1'b0;
      end
      heading[w] = held;

      ticks = '0;
      if (reported != DIR_STOP) begin
         if (!wrapped) begin
            ticks = count - last_count[w];
         end else if (count <= glitch_limit) begin
            ticks = count;
         end else begin
            glitch_drops++;
         end
      end
      last_count[w] = count;
      tick_sum[w] = tick_sum[w] + TOTAL_WIDTH'(ticks);
      if (held == DIR_FWD) begin
         signed_sum[w] = signed_sum[w] + TOTAL_WIDTH'(ticks);
      end else if (held == DIR_REV) begin
         signed_sum[w] = signed_sum[w] - TOTAL_WIDTH'(ticks);
      end

      signed_total = signed_sum[w];
      abs_total    = tick_sum[w];
      if (held == DIR_FWD) begin
         signed_speed = {1'b0, speed};
      end else if (held == DIR_REV) begin
         signed_speed = SSPEED_WIDTH'(0) - {1'b0, speed};
      end else begin
         signed_speed = '0;
      end
   endfunction

   // Left wheel first, then right, each with its own state.
   function automatic odo_result_type predict_odometry(input status_frame_type f);
      odo_result_type r;
      advance_wheel(0, f.direction[DIR_LEFT_LSB +: 2], f.lspeed, f.left_count,
                    r.left_signed_total, r.left_abs_total, r.left_signed_speed);
      advance_wheel(1, f.direction[DIR_RIGHT_LSB +: 2], f.rspeed, f.right_count,
                    r.right_signed_total, r.right_abs_total, r.right_signed_speed);
      return r;
   endfunction

   // Mostly well-formed frames: directions that persist for a while, counters that climb
   // and now and then drop back, and speed bytes that are often zero so that the
   // reversal filter has to wait for counter resets. A few frames are pure noise.
   function automatic status_frame_type random_frame();
      status_frame_type       f;
      logic [COUNT_WIDTH-1:0] cnt;
      int                     pick;
      int                     top;
      f.frame_ok = ($urandom_range(99) >= 6);
      f.lspeed   = ($urandom_range(99) < 45) ? '0 : BYTE_WIDTH'($urandom);
      f.rspeed   = ($urandom_range(99) < 45) ? '0 : BYTE_WIDTH'($urandom);
      for (int w = 0; w < 2; w++) begin
         if ($urandom_range(99) < 15) begin
            gen_pair[w] = 2'($urandom);
         end
      end
      if ($urandom_range(99) < 5) begin
         f.direction = BYTE_WIDTH'($urandom);
      end else begin
         f.direction = {gen_pair[0], gen_pair[1], 4'($urandom)};
      end
      top = int'(glitch_limit) + 40;
      if (top > 65535) begin
         top = 65535;
      end
      for (int w = 0; w < 2; w++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            cnt = COUNT_WIDTH'($urandom);
         end else if (pick < 25) begin
            cnt = COUNT_WIDTH'($urandom_range(top, 0));
         end else begin
            cnt = gen_count[w] + COUNT_WIDTH'($urandom_range(400));
         end
         if (f.frame_ok) begin
            gen_count[w] = cnt;
         end
         if (w == 0) begin
            f.left_count = cnt;
         end else begin
            f.right_count = cnt;
         end
      end
      return f;
   endfunction

   // Offers one frame, possibly after some idle cycles, and waits for the handshake.
   // Called at a rising edge; returns at the edge where the transaction was taken.
   task automatic send_frame(input status_frame_type f, input bit known,
                             input odo_result_type want);
      logic [REQ_DATA_WIDTH-1:0] word;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      word = '0;
      word[REQ_DIR_LSB    +: BYTE_WIDTH]  = f.direction;
      word[REQ_LSPEED_LSB +: BYTE_WIDTH]  = f.lspeed;
      word[REQ_RSPEED_LSB +: BYTE_WIDTH]  = f.rspeed;
      word[REQ_LCOUNT_LSB +: COUNT_WIDTH] = f.left_count;
      word[REQ_RCOUNT_LSB +: COUNT_WIDTH] = f.right_count;
      req_tvalid <= 1'b1;
      req_tuser  <= f.frame_ok;
      req_tdata  <= word;
      do begin
         @(posedge clock);
      end while (!req_tready);
      frames_accepted++;
      // Invalid frames leave the state alone and produce nothing.
      if (f.frame_ok) begin
         if (known) begin
            void'(predict_odometry(f));
            pending_odometry.push_back(want);
         end else begin
            pending_odometry.push_back(predict_odometry(f));
         end
      end
   endtask

   // Stops offering frames until every outstanding result has come back.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_odometry.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_odometry.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", pending_odometry.size()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the glitch limit while the block is idle and mirrors it in the predictor.
   task automatic write_glitch_limit(input logic [CFG_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      glitch_limit = value;
   endtask

   // Receiver: random back-pressure, plus a long hold-off whenever the stimulus asks for
   // one. The hold is counted here so the sender can keep offering frames meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Result checker: every response transaction is matched against the oldest expectation.
   always @(posedge clock) begin
      odo_result_type got;
      odo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_signed_total  = rsp_tdata[0 * TOTAL_WIDTH +: TOTAL_WIDTH];
         got.right_signed_total = rsp_tdata[1 * TOTAL_WIDTH +: TOTAL_WIDTH];
         got.left_abs_total     = rsp_tdata[2 * TOTAL_WIDTH +: TOTAL_WIDTH];
         got.right_abs_total    = rsp_tdata[3 * TOTAL_WIDTH +: TOTAL_WIDTH];
         got.left_signed_speed  = rsp_tdata[RSP_SPEED_LSB +: SSPEED_WIDTH];
         got.right_signed_speed = rsp_tdata[RSP_SPEED_LSB + SSPEED_WIDTH +: SSPEED_WIDTH];
         if (pending_odometry.size() == 0) begin
            flag_error("result transaction with no frame outstanding");
         end else begin
            want = pending_odometry.pop_front();
            results_checked++;
            check_field("left_signed_total", want.left_signed_total, got.left_signed_total);
            check_field("right_signed_total", want.right_signed_total,
                        got.right_signed_total);
            check_field("left_abs_total", want.left_abs_total, got.left_abs_total);
            check_field("right_abs_total", want.right_abs_total, got.right_abs_total);
            check_field("left_signed_speed", TOTAL_WIDTH'(want.left_signed_speed),
                        TOTAL_WIDTH'(got.left_signed_speed));
            check_field("right_signed_speed", TOTAL_WIDTH'(want.right_signed_speed),
                        TOTAL_WIDTH'(got.right_signed_speed));
            check_field("zero fill", '0,
                        TOTAL_WIDTH'(rsp_tdata[RSP_DATA_WIDTH-1:RSP_FIELDS]));
         end
      end
   end

   // Stimulus: directed table first, then four random phases with different glitch
   // limits, the first two also under random back-pressure.
   initial begin
      table_row_type    rows [DIRECTED_ROWS];
      status_frame_type f;
      int               sent;
      logic [CFG_WIDTH-1:0] limit;

      // Directed frames. The first rows start from the reset state, so their results can
      // be written down directly; the rest walk through the reversal filter, glitches at
      // and just over the limit of 300, and direction pairs with only one bit set.
      rows = '{
         // Invalid frame with every bit set: ignored, no result.
         '{'{1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_TICKS},
         // Stop reports while stopped: nothing accumulates, even across two resets.
         '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000}, 1'b1, NO_TICKS},
         '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'd50,   16'd50},   1'b1, NO_TICKS},
         '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'd20,   16'd20},   1'b1, NO_TICKS},
         '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'd10,   16'd10},   1'b1, NO_TICKS},
         // Forward while stopped is adopted even with zero speed.
         '{'{1'b1, 8'hF0, 8'h00, 8'h00, 16'd110,  16'd210},  1'b1,
           '{32'sd100, 32'sd200, 32'd100, 32'd200, 9'sd0, 9'sd0}},
         // Largest counters and speeds.
         '{'{1'b1, 8'hF0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1,
           '{32'sd65525, 32'sd65525, 32'd65525, 32'd65525, 9'sd255, 9'sd255}},
         // Invalid frame in the middle: the state must not move.
         '{'{1'b0, 8'hA5, 8'h0C, 8'h22, 16'd1,    16'd2},    1'b0, NO_TICKS},
         // Reversal reported at zero speed: held off until the second counter reset.
         '{'{1'b1, 8'hA0, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF}, 1'b0, NO_TICKS},
         '{'{1'b1, 8'hA0, 8'h00, 8'h00, 16'd10,   16'd300},  1'b0, NO_TICKS},
         '{'{1'b1, 8'hA0, 8'h00, 8'h00, 16'd5,    16'd299},  1'b0, NO_TICKS},
         '{'{1'b1, 8'hA0, 8'h00, 8'h00, 16'd1000, 16'd1000}, 1'b0, NO_TICKS},
         // Counter drops to just above the limit: a glitch, no ticks.
         '{'{1'b1, 8'hA0, 8'h00, 8'h00, 16'd301,  16'd400},  1'b0, NO_TICKS},
         // Only the lower bit of each pair set: reads as stop.
         '{'{1'b1, 8'h50, 8'h07, 8'h07, 16'd500,  16'd500},  1'b0, NO_TICKS},
         '{'{1'b1, 8'hCF, 8'h01, 8'h00, 16'd600,  16'd0},    1'b0, NO_TICKS},
         // Reverse with nonzero speed is adopted at once.
         '{'{1'b1, 8'h80, 8'hC8, 8'h03, 16'd650,  16'd20},   1'b0, NO_TICKS},
         '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'd0,    16'd0},    1'b0, NO_TICKS},
         '{'{1'b1, 8'h30, 8'h00, 8'h80, 16'hFFFF, 16'h8000}, 1'b0, NO_TICKS}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_frame(rows[i].frame, rows[i].known, rows[i].want);
      end
      gen_count[0] = last_count[0];
      gen_count[1] = last_count[1];

      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         case (phase)
            0: begin
               tx_idle_pct = 28;
               rx_idle_pct = 66;
               limit = '0;
            end
            1: begin
               tx_idle_pct = 66;
               rx_idle_pct = 28;
               limit = '1;
            end
            2: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               limit = CFG_WIDTH'($urandom_range(600, 50));
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               limit = CFG_WIDTH'($urandom);
            end
         endcase
         write_glitch_limit(limit);
         sent = 0;
         while (sent < PHASE_FRAMES) begin
            f = random_frame();
            send_frame(f, 1'b0, NO_TICKS);
            if (f.frame_ok) begin
               sent++;
               // Halfway through, either stall the receiver for a long stretch while
               // frames keep coming, or let the sender wait for a full drain.
               if (sent == PHASE_FRAMES / 2) begin
                  if (phase == 1) begin
                     drain_results();
                  end else begin
                     hold_requests++;
                  end
               end
            end
         end
      end

      drain_results();
      $display("Covered %0d frames (%0d results checked) across glitch limits 300, 0, 65535",
               frames_accepted, results_checked);
      $display("and two random ones; %0d glitch drops, %0d reversals taken after two resets.",
               glitch_drops, late_reversals);
      if (errors == 0) begin
         $display("tb_wheel_odometry_direction_filter: done, clean");
      end else begin
         $display("tb_wheel_odometry_direction_filter: done, errors");
      end
      $finish;
   end

   // Watchdog for a block that hangs or never answers.
   initial begin
      #2000000;
      $display("tb_wheel_odometry_direction_filter: done, errors");
      $finish;
   end

endmodule
